FILE: src/nfaer_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the NFA epsilon-removal engine.
// Used by every module of the block; depends on nothing else.
package nfaer_pkg;

  localparam int NODES    = 16;
  localparam int SYMS     = 4;
  localparam int ST_W     = $clog2(NODES);
  localparam int SYM_W    = $clog2(SYMS);
  localparam int ADDR_W   = ST_W + SYM_W;
  localparam int ROWS     = NODES * SYMS;
  localparam int CNT_W    = $clog2(NODES + 1);
  localparam int OP_W     = 3;
  localparam int NS_W     = 5;
  localparam int NSYM_W   = 3;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_EPS = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_SYM = 3'd2;
  localparam logic [OP_W-1:0] OP_QMOVE   = 3'd3;
  localparam logic [OP_W-1:0] OP_QCLOS   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_STATES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SYMBOLS = 1'b1;

  localparam logic KIND_MOVE    = 1'b0;
  localparam logic KIND_CLOSURE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_CLOS_A,
    ST_HIT_RD,
    ST_HIT_ACC,
    ST_CLOS_B,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic            clr;
    logic            we;
    logic [ST_W-1:0] row;
    logic [ST_W-1:0] col;
  } eps_req_t;

  typedef struct packed {
    logic              clr;
    logic              rd;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [NODES-1:0]  wdata;
  } sym_req_t;

  typedef struct packed {
    logic [NS_W-1:0]   n_eff;
    logic [NSYM_W-1:0] m_eff;
    logic [NODES-1:0]  mask;
  } cfg_t;

  function automatic logic [ST_W-1:0] lowest_bit(input logic [NODES-1:0] v);
    logic [ST_W-1:0] idx;
    idx = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (v[i]) idx = ST_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [NODES-1:0] one_hot(input logic [ST_W-1:0] idx);
    logic [NODES-1:0] v;
    v = '0;
    v[idx] = 1'b1;
    return v;
  endfunction

endpackage

FILE: src/nfaer_eps_store.sv
`timescale 1ns / 1ps
// Epsilon edge matrix held in flip-flops, one row per source state.
// Depends on nfaer_pkg for the request struct and sizes.
module nfaer_eps_store import nfaer_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  eps_req_t         eps_req,
  input  logic [ST_W-1:0]  rd_idx,
  output logic [NODES-1:0] rd_row
);

  logic [NODES-1:0] eps_r [NODES];

  always_ff @(posedge clk) begin
    if (!rst_n || eps_req.clr) begin
      for (int i = 0; i < NODES; i++) begin
        eps_r[i] <= '0;
      end
    end else if (eps_req.we) begin
      eps_r[eps_req.row][eps_req.col] <= 1'b1;
    end
  end

  assign rd_row = eps_r[rd_idx];

endmodule

FILE: src/nfaer_sym_store.sv
`timescale 1ns / 1ps
// Symbol edge memory, one row per state and symbol, with per-row valid bits.
// Rows that are not valid read as zero. Depends on nfaer_pkg.
module nfaer_sym_store import nfaer_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  sym_req_t         sym_req,
  output logic [NODES-1:0] rd_row
);

  logic [NODES-1:0] mem [ROWS];
  logic [ROWS-1:0]  vld_r;
  logic [NODES-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (sym_req.clr) begin
        vld_r <= '0;
      end else if (sym_req.we) begin
        vld_r[sym_req.addr] <= 1'b1;
      end
      if (sym_req.rd) begin
        rd_vld_r <= vld_r[sym_req.addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sym_req.we) begin
      mem[sym_req.addr] <= sym_req.wdata;
    end
    if (sym_req.rd) begin
      rd_data_r <= mem[sym_req.addr];
    end
  end

  assign rd_row = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: src/nfaer_ctrl.sv
`timescale 1ns / 1ps
// Sequencer and shared set unit: closure steps, symbol row gathering and the
// output register. Depends on nfaer_pkg and drives both edge stores.
module nfaer_ctrl import nfaer_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [ST_W-1:0]   in_from_state,
  input  logic [SYM_W-1:0]  in_symbol_index,
  input  logic [ST_W-1:0]   in_to_state,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_result_kind,
  output logic [NODES-1:0]  out_reached_set,
  output logic [CNT_W-1:0]  out_reached_count,
  output eps_req_t          eps_req,
  output logic [ST_W-1:0]   eps_rd_idx,
  input  logic [NODES-1:0]  eps_row,
  output sym_req_t          sym_req,
  input  logic [NODES-1:0]  sym_row
);

  seq_state_t        state_r, state_nxt;
  logic              kind_r, kind_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [ST_W-1:0]   dst_r, dst_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [NODES-1:0]  set_r, set_nxt;
  logic [NODES-1:0]  pend_r, pend_nxt;
  logic [NODES-1:0]  hit_r, hit_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [NODES-1:0]  out_set_r, out_set_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic              in_acc;
  logic              out_free;
  logic              src_ok, dst_ok, sym_ok, q_ok;
  logic [ST_W-1:0]   k;
  logic [NODES-1:0]  row_m;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign src_ok = (NS_W'(in_from_state) < cfg.n_eff);
  assign dst_ok = (NS_W'(in_to_state) < cfg.n_eff);
  assign sym_ok = (NSYM_W'(in_symbol_index) < cfg.m_eff);
  assign q_ok   = src_ok && ((in_opcode == OP_QCLOS) || sym_ok);

  assign k          = lowest_bit(pend_r);
  assign eps_rd_idx = k;
  assign row_m      = eps_row & cfg.mask;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_opcode)
            OP_ADD_SYM: begin
              if (src_ok && dst_ok && sym_ok) state_nxt = ST_EDGE_WR;
            end
            OP_QMOVE, OP_QCLOS: begin
              state_nxt = q_ok ? ST_CLOS_A : ST_DONE;
            end
            default: ;
          endcase
        end
      end
      ST_EDGE_WR: state_nxt = ST_IDLE;
      ST_CLOS_A: begin
        if (pend_r == '0) state_nxt = (kind_r == KIND_MOVE) ? ST_HIT_RD : ST_DONE;
      end
      ST_HIT_RD:  state_nxt = (pend_r == '0) ? ST_CLOS_B : ST_HIT_ACC;
      ST_HIT_ACC: state_nxt = ST_HIT_RD;
      ST_CLOS_B: begin
        if (pend_r == '0) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt      = kind_r;
    sym_nxt       = sym_r;
    dst_nxt       = dst_r;
    addr_nxt      = addr_r;
    set_nxt       = set_r;
    pend_nxt      = pend_r;
    hit_nxt       = hit_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_set_nxt   = out_set_r;
    out_cnt_nxt   = out_cnt_r;
    eps_req       = '0;
    sym_req       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          kind_nxt = (in_opcode == OP_QCLOS) ? KIND_CLOSURE : KIND_MOVE;
          sym_nxt  = in_symbol_index;
          dst_nxt  = in_to_state;
          addr_nxt = {in_from_state, in_symbol_index};
          set_nxt  = q_ok ? one_hot(in_from_state) : '0;
          pend_nxt = q_ok ? one_hot(in_from_state) : '0;
          cnt_nxt  = '0;
          case (in_opcode)
            OP_CLEAR: begin
              eps_req.clr = 1'b1;
              sym_req.clr = 1'b1;
            end
            OP_ADD_EPS: begin
              eps_req.we  = src_ok && dst_ok;
              eps_req.row = in_from_state;
              eps_req.col = in_to_state;
            end
            OP_ADD_SYM: begin
              sym_req.rd   = src_ok && dst_ok && sym_ok;
              sym_req.addr = {in_from_state, in_symbol_index};
            end
            default: ;
          endcase
        end
      end
      ST_EDGE_WR: begin
        sym_req.we    = 1'b1;
        sym_req.addr  = addr_r;
        sym_req.wdata = sym_row | one_hot(dst_r);
      end
      ST_CLOS_A, ST_CLOS_B: begin
        if (pend_r != '0) begin
          set_nxt  = set_r | row_m;
          pend_nxt = (pend_r & ~one_hot(k)) | (row_m & ~set_r);
          cnt_nxt  = cnt_r + CNT_W'(1);
        end else if (state_r == ST_CLOS_A && kind_r == KIND_MOVE) begin
          pend_nxt = set_r;
          hit_nxt  = '0;
        end
      end
      ST_HIT_RD: begin
        if (pend_r != '0) begin
          sym_req.rd   = 1'b1;
          sym_req.addr = {k, sym_r};
          pend_nxt     = pend_r & ~one_hot(k);
        end else begin
          set_nxt  = hit_r & cfg.mask;
          pend_nxt = hit_r & cfg.mask;
          cnt_nxt  = '0;
        end
      end
      ST_HIT_ACC: begin
        hit_nxt = hit_r | sym_row;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_set_nxt   = set_r;
          out_cnt_nxt   = cnt_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    sym_r      <= sym_nxt;
    dst_r      <= dst_nxt;
    addr_r     <= addr_nxt;
    set_r      <= set_nxt;
    pend_r     <= pend_nxt;
    hit_r      <= hit_nxt;
    cnt_r      <= cnt_nxt;
    out_kind_r <= out_kind_nxt;
    out_set_r  <= out_set_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_reached_set   = out_set_r;
  assign out_reached_count = out_cnt_r;

endmodule

FILE: src/nfa_epsilon_removal_top.sv
`timescale 1ns / 1ps
// NFA epsilon-closure and epsilon-free move engine, top level with config registers.
// A symbol edge write is a memory read-modify-write through ST_EDGE_WR.
// A closure query steps one state per cycle; a move query also reads its symbol rows
// one state at a time through the single symbol memory port.
// One item at a time; a finished result waits in the output register meanwhile.
// Synchronous active-low reset clears all edges and sets 16 states and 4 symbols.
module nfa_epsilon_removal_top import nfaer_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [ST_W-1:0]      in_from_state,
  input  logic [SYM_W-1:0]     in_symbol_index,
  input  logic [ST_W-1:0]      in_to_state,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_result_kind,
  output logic [NODES-1:0]     out_reached_set,
  output logic [CNT_W-1:0]     out_reached_count
);

  logic [NS_W-1:0]   num_states_r;
  logic [NSYM_W-1:0] num_symbols_r;
  cfg_t              cfg;
  eps_req_t          eps_req;
  sym_req_t          sym_req;
  logic [ST_W-1:0]   eps_rd_idx;
  logic [NODES-1:0]  eps_row;
  logic [NODES-1:0]  sym_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r  <= NS_W'(NODES);
      num_symbols_r <= NSYM_W'(SYMS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_STATES:  num_states_r  <= cfg_data[NS_W-1:0];
        REG_NUM_SYMBOLS: num_symbols_r <= cfg_data[NSYM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.n_eff = (num_states_r > NS_W'(NODES)) ? NS_W'(NODES) : num_states_r;
    cfg.m_eff = (num_symbols_r > NSYM_W'(SYMS)) ? NSYM_W'(SYMS) : num_symbols_r;
    for (int i = 0; i < NODES; i++) begin
      cfg.mask[i] = (NS_W'(i) < cfg.n_eff);
    end
  end

  nfaer_eps_store u_eps_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .eps_req (eps_req),
    .rd_idx  (eps_rd_idx),
    .rd_row  (eps_row)
  );

  nfaer_sym_store u_sym_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .sym_req (sym_req),
    .rd_row  (sym_row)
  );

  nfaer_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_from_state     (in_from_state),
    .in_symbol_index   (in_symbol_index),
    .in_to_state       (in_to_state),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_reached_set   (out_reached_set),
    .out_reached_count (out_reached_count),
    .eps_req           (eps_req),
    .eps_rd_idx        (eps_rd_idx),
    .eps_row           (eps_row),
    .sym_req           (sym_req),
    .sym_row           (sym_row)
  );

endmodule

FILE: src/nfaer_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the NFA epsilon-removal engine, bound to the top level.
// Depends on nfaer_pkg for opcodes and widths.
module nfaer_checker import nfaer_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [OP_W-1:0]  in_opcode,
  input logic             out_valid,
  input logic             out_stall,
  input logic [NODES-1:0] out_reached_set,
  input logic [CNT_W-1:0] out_reached_count
);

  // A result beat reports the population count of its own set.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reached_count == CNT_W'($countones(out_reached_set))))
    else $error("reached_count does not match reached_set");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_reached_set)
                                  && $stable(out_reached_count)))
    else $error("stalled result beat changed");

  // Edge updates and unknown opcodes never produce a result beat.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid && in_opcode != OP_QMOVE
     && in_opcode != OP_QCLOS) |=> !out_valid)
    else $error("result beat without a query");

  // A query occupies the engine for at least the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_opcode == OP_QMOVE || in_opcode == OP_QCLOS))
    |=> in_stall)
    else $error("query accepted but engine not busy");

endmodule

bind nfa_epsilon_removal_top nfaer_checker u_nfaer_checker (.*);

FILE: dv/nfa_epsilon_removal_checker.sv
`timescale 1ns / 1ps
// Checker for the NFA epsilon-removal engine. It watches the config port and both channels,
// predicts every answer from its own edge matrices, and compares it. Depends on nfaer_pkg.
module nfa_epsilon_removal_checker import nfaer_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [ST_W-1:0]      in_from_state,
  input  logic [SYM_W-1:0]     in_symbol_index,
  input  logic [ST_W-1:0]      in_to_state,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_result_kind,
  input  logic [NODES-1:0]     out_reached_set,
  input  logic [CNT_W-1:0]     out_reached_count,
  output int                   fail_count,
  output int                   pending,
  output int                   beats_seen,
  output int                   answers_seen
);

  typedef struct packed {
    logic             kind;
    logic [NODES-1:0] states;
    logic [CNT_W-1:0] count;
  } answer_t;

  logic [NODES-1:0] eps_rows [NODES];
  logic [NODES-1:0] sym_rows [ROWS];
  logic [NS_W-1:0]   states_reg;
  logic [NSYM_W-1:0] symbols_reg;
  answer_t           answers_due[$];
  int                mismatches;
  int                beats;
  int                answers;

  function automatic logic [NODES-1:0] eps_closure(input logic [NODES-1:0] seed, input int n);
    logic [NODES-1:0] live;
    logic [NODES-1:0] reach;
    logic [NODES-1:0] grown;
    live = '0;
    for (int k = 0; k < n; k++) live[k] = 1'b1;
    reach = seed & live;
    for (int r = 0; r < n; r++) begin
      grown = reach;
      for (int k = 0; k < n; k++) begin
        if (reach[k]) grown |= eps_rows[k];
      end
      reach = grown & live;
    end
    return reach;
  endfunction

  function automatic void absorb_beat(input logic [OP_W-1:0] op, input logic [ST_W-1:0] src,
                                      input logic [SYM_W-1:0] sym, input logic [ST_W-1:0] dst);
    int               n;
    int               m;
    logic [NODES-1:0] seed;
    logic [NODES-1:0] reach;
    logic [NODES-1:0] hits;
    logic [NODES-1:0] ans;
    answer_t          a;
    n = (states_reg > NODES) ? NODES : int'(states_reg);
    m = (symbols_reg > SYMS) ? SYMS : int'(symbols_reg);
    seed = '0;
    seed[src] = 1'b1;
    hits = '0;
    ans = '0;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < NODES; i++) eps_rows[i] = '0;
        for (int i = 0; i < ROWS; i++) sym_rows[i] = '0;
      end
      OP_ADD_EPS: begin
        if (src < n && dst < n) eps_rows[src][dst] = 1'b1;
      end
      OP_ADD_SYM: begin
        if (src < n && dst < n && sym < m) sym_rows[int'(src) * SYMS + int'(sym)][dst] = 1'b1;
      end
      OP_QMOVE, OP_QCLOS: begin
        if (op == OP_QCLOS && src < n) ans = eps_closure(seed, n);
        if (op == OP_QMOVE && src < n && sym < m) begin
          reach = eps_closure(seed, n);
          for (int k = 0; k < n; k++) begin
            if (reach[k]) hits |= sym_rows[k * SYMS + int'(sym)];
          end
          ans = eps_closure(hits, n);
        end
        a.kind = (op == OP_QCLOS) ? KIND_CLOSURE : KIND_MOVE;
        a.states = ans;
        a.count = CNT_W'($countones(ans));
        answers_due.push_back(a);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) eps_rows[i] = '0;
      for (int i = 0; i < ROWS; i++) sym_rows[i] = '0;
      states_reg = NS_W'(NODES);
      symbols_reg = NSYM_W'(SYMS);
      answers_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NUM_STATES) states_reg = cfg_data[NS_W-1:0];
        else if (cfg_index == REG_NUM_SYMBOLS) symbols_reg = cfg_data[NSYM_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected answer beat", 0, int'(out_reached_set));
        end else begin
          want = answers_due.pop_front();
          if (out_result_kind !== want.kind)
            report_mismatch("result_kind", int'(want.kind), int'(out_result_kind));
          if (out_reached_set !== want.states)
            report_mismatch("reached_set", int'(want.states), int'(out_reached_set));
          if (out_reached_count !== want.count)
            report_mismatch("reached_count", int'(want.count), int'(out_reached_count));
          answers++;
        end
      end
      if (in_valid && !in_stall) begin
        absorb_beat(in_opcode, in_from_state, in_symbol_index, in_to_state);
        beats++;
      end
    end
    pending <= answers_due.size();
    fail_count <= mismatches;
    beats_seen <= beats;
    answers_seen <= answers;
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the NFA epsilon-removal testbench: clock, reset, config writes and beat stimulus.
// Depends on nfaer_pkg, nfa_epsilon_removal_top and nfa_epsilon_removal_checker.
module testbench;
  import nfaer_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 64;
  localparam int PHASES          = 8;
  localparam int FIRST_UNUSED_OP = int'(OP_QCLOS) + 1;
  localparam int LAST_OP         = (1 << OP_W) - 1;
  localparam int STATES_CFG  [PHASES] = '{16, 5, 1, 31, 0, 9, 17, 16};
  localparam int SYMBOLS_CFG [PHASES] = '{4, 2, 1, 7, 0, 27, 4, 1};
  localparam int PHASE_ITEMS [PHASES] = '{300, 150, 80, 250, 50, 150, 150, 170};
  localparam int IDLE_PCT  [4] = '{0, 56, 0, 13};
  localparam int STALL_PCT [4] = '{0, 0, 56, 13};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode;
  logic [ST_W-1:0]      in_from_state;
  logic [SYM_W-1:0]     in_symbol_index;
  logic [ST_W-1:0]      in_to_state;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_result_kind;
  logic [NODES-1:0]     out_reached_set;
  logic [CNT_W-1:0]     out_reached_count;

  int idle_pct;
  int stall_pct;
  int cur_states;
  int cur_symbols;
  int cycle_count = 0;
  int fail_count;
  int pending;
  int beats_seen;
  int answers_seen;

  always #6 clk = ~clk;

  nfa_epsilon_removal_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_from_state     (in_from_state),
    .in_symbol_index   (in_symbol_index),
    .in_to_state       (in_to_state),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_reached_set   (out_reached_set),
    .out_reached_count (out_reached_count)
  );

  nfa_epsilon_removal_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_from_state     (in_from_state),
    .in_symbol_index   (in_symbol_index),
    .in_to_state       (in_to_state),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_reached_set   (out_reached_set),
    .out_reached_count (out_reached_count),
    .fail_count        (fail_count),
    .pending           (pending),
    .beats_seen        (beats_seen),
    .answers_seen      (answers_seen)
  );

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_beat(input logic [OP_W-1:0] op, input int src, input int sym,
                           input int dst);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_from_state <= ST_W'(src);
    in_symbol_index <= SYM_W'(sym);
    in_to_state <= ST_W'(dst);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_beat();
    int               n;
    int               m;
    int               roll;
    int               src;
    int               sym;
    int               dst;
    logic [OP_W-1:0]  op;
    n = (cur_states > NODES) ? NODES : cur_states;
    m = (cur_symbols > SYMS) ? SYMS : cur_symbols;
    roll = $urandom_range(99);
    if (roll < 2) op = OP_CLEAR;
    else if (roll < 30) op = OP_ADD_EPS;
    else if (roll < 56) op = OP_ADD_SYM;
    else if (roll < 79) op = OP_QMOVE;
    else if (roll < 97) op = OP_QCLOS;
    else op = OP_W'($urandom_range(LAST_OP, FIRST_UNUSED_OP));
    src = (n > 0 && $urandom_range(9) != 0) ? $urandom_range(n - 1) : $urandom_range(NODES - 1);
    dst = (n > 0 && $urandom_range(9) != 0) ? $urandom_range(n - 1) : $urandom_range(NODES - 1);
    sym = (m > 0 && $urandom_range(9) != 0) ? $urandom_range(m - 1) : $urandom_range(SYMS - 1);
    send_beat(op, src, sym, dst);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_counts(input int states, input int symbols);
    cfg_we <= 1'b1;
    cfg_index <= REG_NUM_STATES;
    cfg_data <= CFG_W'(states);
    @(posedge clk);
    cfg_index <= REG_NUM_SYMBOLS;
    cfg_data <= CFG_W'(symbols);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_states = states % (1 << NS_W);
    cur_symbols = symbols % (1 << NSYM_W);
  endtask

  initial begin
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_opcode = OP_CLEAR;
    in_from_state = '0;
    in_symbol_index = '0;
    in_to_state = '0;
    idle_pct = 0;
    stall_pct = 0;
    cur_states = NODES;
    cur_symbols = SYMS;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(OP_CLEAR, 0, 0, 0);
    send_beat(OP_QCLOS, 0, 0, 0);
    send_beat(OP_QMOVE, 0, 0, 0);
    send_beat(OP_ADD_EPS, 0, 0, 15);
    send_beat(OP_ADD_EPS, 15, 0, 7);
    send_beat(OP_ADD_EPS, 7, 0, 3);
    send_beat(OP_QCLOS, 0, 3, 0);
    send_beat(OP_ADD_SYM, 3, 3, 9);
    send_beat(OP_ADD_EPS, 9, 0, 15);
    send_beat(OP_QMOVE, 0, 3, 0);
    send_beat(OP_ADD_EPS, 15, 0, 15);
    send_beat(OP_ADD_EPS, 3, 0, 0);
    send_beat(OP_QCLOS, 9, 0, 0);
    send_beat(OP_ADD_SYM, 15, 0, 0);
    send_beat(OP_QMOVE, 15, 0, 15);
    for (int op = FIRST_UNUSED_OP; op <= LAST_OP; op++) send_beat(OP_W'(op), 15, 3, 15);
    send_beat(OP_QCLOS, 15, 3, 15);
    send_beat(OP_QMOVE, 15, 3, 15);
    send_beat(OP_CLEAR, 15, 3, 15);
    send_beat(OP_QCLOS, 0, 0, 0);
    send_beat(OP_QMOVE, 0, 3, 0);

    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      write_counts(STATES_CFG[p], SYMBOLS_CFG[p]);
      idle_pct = IDLE_PCT[p % 4];
      stall_pct = STALL_PCT[p % 4];
      for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
        if (i == PHASE_ITEMS[p] / 2) quiesce();
        random_beat();
      end
    end
    quiesce();

    $display("Checked %0d answers from %0d beats over %0d register settings,",
             answers_seen, beats_seen, PHASES + 1);
    $display("with edge building, clears, out-of-range items and four idle/stall mixes.");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
